// ----- hdl/bqf_pkg.sv -----
// Package for the cascaded biquad filter bank: field widths, storage word layouts,
// reset values and the section result record.
// No dependencies; every other file of the block but bqf_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package bqf_pkg;

  localparam int BANK_W      = 6;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 32;
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 7;
  localparam int PROD_W      = COEF_W + DATA_W;
  localparam int ACC_W       = PROD_W + 3;
  localparam int FRAC_SHIFT  = 28;
  localparam int NUM_BANKS_DEFAULT = 64;

  localparam logic [CFG_W-1:0] BANKS_IN_USE_RESET = 7'd64;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_FILTER = 1'b1;

  // One bank's coefficients, all signed Q3.28.
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  // One bank's delay line: two raw input samples, two first-section outputs
  // and two second-section outputs (Q23.8).
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [DATA_W-1:0]   m1;
    logic signed [DATA_W-1:0]   m2;
    logic signed [DATA_W-1:0]   o1;
    logic signed [DATA_W-1:0]   o2;
  } delay_t;

  // Result of one pass through the section datapath.
  typedef struct packed {
    logic                     valid;
    logic                     clip;
    logic signed [DATA_W-1:0] y;
  } sec_res_t;

endpackage

`default_nettype wire

// ----- hdl/bqf_req_if.sv -----
// Input channel of the filter bank: handshake plus one request word.
// Depends on bqf_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bqf_req_if import bqf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [BANK_W-1:0]          bank;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [COEF_W-1:0]   coef_b0;
  logic signed [COEF_W-1:0]   coef_b1;
  logic signed [COEF_W-1:0]   coef_b2;
  logic signed [COEF_W-1:0]   coef_a1;
  logic signed [COEF_W-1:0]   coef_a2;

  modport source (output valid, func, bank, sample, coef_b0, coef_b1, coef_b2,
                  coef_a1, coef_a2, input ready);
  modport sink (input valid, func, bank, sample, coef_b0, coef_b1, coef_b2,
                coef_a1, coef_a2, output ready);
endinterface

`default_nettype wire

// ----- hdl/bqf_rsp_if.sv -----
// Output channel of the filter bank: handshake plus one result word.
// Depends on bqf_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bqf_rsp_if import bqf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [BANK_W-1:0]        bank_out;
  logic signed [DATA_W-1:0] filtered;
  logic                     saturated;

  modport source (output valid, bank_out, filtered, saturated, input ready);
  modport sink (input valid, bank_out, filtered, saturated, output ready);
endinterface

`default_nettype wire

// ----- hdl/bqf_cfg_if.sv -----
// Configuration write channel: handshake plus the banks-in-use value.
// Depends on bqf_pkg for the register width.
`timescale 1ns / 1ps
`default_nettype none

interface bqf_cfg_if import bqf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/bqf_ram.sv -----
// Simple dual-port synchronous memory, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bqf_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bqf_section.sv -----
// One direct-form-1 biquad section: five registered products, a two-step sum
// with rounding, and saturation to Q23.8.
// Depends on bqf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bqf_section import bqf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  coef_t                    coef,
  input  logic signed [DATA_W-1:0] x0,
  input  logic signed [DATA_W-1:0] x1,
  input  logic signed [DATA_W-1:0] x2,
  input  logic signed [DATA_W-1:0] y1,
  input  logic signed [DATA_W-1:0] y2,
  output sec_res_t                 res
);

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_SHIFT - 1);
  localparam int Q_W = ACC_W - FRAC_SHIFT;

  logic [2:0]               stage_v;
  logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0]  sum_ff, sum_fb;
  logic signed [ACC_W-1:0]  acc;
  logic signed [Q_W-1:0]    q;
  logic                     fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      stage_v <= {stage_v[1:0], go};
    end
  end

  always_ff @(posedge clk) begin
    p0 <= coef.b0 * x0;
    p1 <= coef.b1 * x1;
    p2 <= coef.b2 * x2;
    p3 <= coef.a1 * y1;
    p4 <= coef.a2 * y2;
    sum_ff <= ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2);
    sum_fb <= ACC_W'(p3) + ACC_W'(p4);
    acc <= sum_ff - sum_fb + ROUND_BIAS;
  end

  // The rounded value fits in 32 bits when every bit above bit 31 equals the sign.
  always_comb begin
    q    = acc[ACC_W-1:FRAC_SHIFT];
    fits = (q[Q_W-1:DATA_W-1] == '0) || (q[Q_W-1:DATA_W-1] == '1);
    res.valid = stage_v[2];
    res.clip  = !fits;
    if (fits) begin
      res.y = q[DATA_W-1:0];
    end else if (q[Q_W-1]) begin
      res.y = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res.y = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cascaded_biquad_filter_bank_unit.sv -----
// Top level of the cascaded biquad filter bank: sequencer, coefficient and
// delay memories, the shared section datapath and the result register.
// Depends on bqf_pkg, bqf_req_if, bqf_rsp_if, bqf_cfg_if, bqf_ram, bqf_section.
//
// A bank of independent IIR filters, each two identical direct-form-1 biquad
// sections in cascade. A load word (func 0) writes a bank's five Q3.28
// coefficients in the cycle it is taken and gives no result. A filter word
// (func 1) reads the bank's coefficients and delay line, runs the section
// datapath twice, writes the delay line back and offers one result word,
// passing through FETCH, SEC1, GO2, SEC2 and FINISH; no new word is taken
// until IDLE again, and FINISH waits for a free result register. The pace is
// set by the three-stage section unit being used once per section, plus the
// registered memory read and the write-back. Words addressing a bank at or
// beyond banks_in_use are dropped. After reset a clearing pass over every bank
// zeroes both memories; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module cascaded_biquad_filter_bank_unit import bqf_pkg::*; #(
  parameter int NUM_BANKS = NUM_BANKS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  bqf_req_if.sink   req,
  bqf_rsp_if.source rsp,
  bqf_cfg_if.sink   cfg
);

  localparam int AW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_FETCH  = 7'b0000100,
    ST_SEC1   = 7'b0001000,
    ST_GO2    = 7'b0010000,
    ST_SEC2   = 7'b0100000,
    ST_FINISH = 7'b1000000
  } fsm_t;

  fsm_t                       state;
  logic [AW-1:0]              clr_addr;
  logic [CFG_W-1:0]           banks_in_use;
  logic [AW-1:0]              cur_addr;
  logic [BANK_W-1:0]          cur_bank;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic signed [DATA_W-1:0]   mid;
  logic signed [DATA_W-1:0]   res_y;
  logic                       clip_any;

  logic    req_take, in_range, load_take, filter_take, commit;
  logic [AW-1:0] req_addr;
  coef_t   coef_wr, coef_rd;
  delay_t  dly_wr, dly_rd;
  logic    coef_we, dly_we;
  logic [AW-1:0] coef_waddr, dly_waddr;
  logic    go, sec2;
  logic signed [DATA_W-1:0] sx0, sx1, sx2, sy1, sy2;
  sec_res_t sres;

  function automatic logic signed [DATA_W-1:0] to_q8(input logic signed [SAMPLE_W-1:0] s);
    return {{(DATA_W-SAMPLE_W-8){s[SAMPLE_W-1]}}, s, 8'd0};
  endfunction

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign req_take  = req.valid && req.ready;
  assign req_addr  = AW'(req.bank);
  assign in_range  = ({1'b0, req.bank} < banks_in_use) && (int'(req.bank) < NUM_BANKS);
  assign load_take   = req_take && in_range && (req.func == FUNC_LOAD);
  assign filter_take = req_take && in_range && (req.func == FUNC_FILTER);
  assign commit    = (state == ST_FINISH) && (!rsp.valid || rsp.ready);

  // Memory write ports: the clearing pass owns both until it ends.
  always_comb begin
    coef_wr = '{b0: req.coef_b0, b1: req.coef_b1, b2: req.coef_b2,
                a1: req.coef_a1, a2: req.coef_a2};
    dly_wr  = '{x1: cur_sample, x2: dly_rd.x1, m1: mid, m2: dly_rd.m1,
                o1: res_y, o2: dly_rd.o1};
    coef_we    = load_take;
    coef_waddr = req_addr;
    dly_we     = commit;
    dly_waddr  = cur_addr;
    if (state == ST_CLEAR) begin
      coef_wr    = '0;
      dly_wr     = '0;
      coef_we    = 1'b1;
      dly_we     = 1'b1;
      coef_waddr = clr_addr;
      dly_waddr  = clr_addr;
    end
  end

  bqf_ram #(.WIDTH($bits(coef_t)), .DEPTH(NUM_BANKS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wr),
    .re    (filter_take),
    .raddr (req_addr),
    .rdata (coef_rd)
  );

  bqf_ram #(.WIDTH($bits(delay_t)), .DEPTH(NUM_BANKS)) u_delay_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (dly_waddr),
    .wdata (dly_wr),
    .re    (filter_take),
    .raddr (req_addr),
    .rdata (dly_rd)
  );

  // The second pass feeds the first section's output and the middle history.
  always_comb begin
    sec2 = (state == ST_GO2);
    go   = (state == ST_FETCH) || sec2;
    if (sec2) begin
      sx0 = mid;
      sx1 = dly_rd.m1;
      sx2 = dly_rd.m2;
      sy1 = dly_rd.o1;
      sy2 = dly_rd.o2;
    end else begin
      sx0 = to_q8(cur_sample);
      sx1 = to_q8(dly_rd.x1);
      sx2 = to_q8(dly_rd.x2);
      sy1 = dly_rd.m1;
      sy2 = dly_rd.m2;
    end
  end

  bqf_section u_section (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .coef (coef_rd),
    .x0   (sx0),
    .x1   (sx1),
    .x2   (sx2),
    .y1   (sy1),
    .y2   (sy2),
    .res  (sres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      banks_in_use <= BANKS_IN_USE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      banks_in_use <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(NUM_BANKS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (filter_take) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: state <= ST_SEC1;
        ST_SEC1: begin
          if (sres.valid) begin
            state <= ST_GO2;
          end
        end
        ST_GO2: state <= ST_SEC2;
        ST_SEC2: begin
          if (sres.valid) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (filter_take) begin
      cur_addr   <= req_addr;
      cur_bank   <= req.bank;
      cur_sample <= req.sample;
    end
    if (state == ST_SEC1 && sres.valid) begin
      mid      <= sres.y;
      clip_any <= sres.clip;
    end
    if (state == ST_SEC2 && sres.valid) begin
      res_y    <= sres.y;
      clip_any <= clip_any | sres.clip;
    end
  end

  // Result register: holds a word until taken while the next item proceeds.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.bank_out  <= cur_bank;
      rsp.filtered  <= res_y;
      rsp.saturated <= clip_any;
    end
  end

  a_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_FINISH))
    else $error("result word appeared without a completed filter pass");

  a_accept_leads_on: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> (state == ST_IDLE || state == ST_FETCH))
    else $error("accepted word did not leave the sequencer idle or fetching");

  a_section_result_expected: assert property (@(posedge clk) disable iff (rst)
    sres.valid |-> (state == ST_SEC1 || state == ST_SEC2))
    else $error("section result arrived outside a section wait");

  a_delay_write_owner: assert property (@(posedge clk) disable iff (rst)
    dly_we |-> (state == ST_CLEAR || state == ST_FINISH))
    else $error("delay memory written outside clearing or commit");

endmodule

`default_nettype wire
